### rtl/tnum_pkg.sv
// ----------------------------------------------------------------------------
// Tristate multiplier package
// Shared word width, tristate word type, variant codes, sequencer states and
// the request bundle for the shared tristate adder.
// ----------------------------------------------------------------------------
package tnum_pkg;

    localparam int WORD_BITS = 64;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        word_t v;
        word_t m;
    } tri_t;

    typedef logic [1:0] variant_t;

    localparam variant_t VAR_LONG       = 2'd0;
    localparam variant_t VAR_EXACT      = 2'd1;
    localparam variant_t VAR_UNION      = 2'd2;
    localparam variant_t VAR_ZERO_UNION = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_MERGE,
        ST_FINAL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic merge;
    } add_req_t;

endpackage

### rtl/tnum_multiplier_unit.sv
// ----------------------------------------------------------------------------
// Tristate number multiplier
// Shift-and-add multiplication of two tristate numbers with four selectable
// accumulation rules, built around one shared two-phase tristate adder.
//
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     a_value a_mask b_value b_mask
// out       output     out_valid / out_ready   product_value product_mask
// cfg       input      cfg_valid / cfg_ready   cfg_data (accumulation rule)
//
// Each bit of a up to its highest set bit takes a pass through ST_STEP when
// certain 0 and through ST_STEP and ST_MERGE otherwise, as every addition
// passes the shared adder in two phases. A last ST_STEP finds a empty, and
// the exact-value rule adds ST_FINAL for the closing addition; ST_IDLE takes
// the operands and ST_DONE hands over the result.
// Reset sets the rule to union of partials and empties the output register.
// A stalled output holds its result and the next transaction is taken only
// once that result has moved into the output register.
// ----------------------------------------------------------------------------
module tnum_multiplier_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  tnum_pkg::word_t          a_value,
    input  tnum_pkg::word_t          a_mask,
    input  tnum_pkg::word_t          b_value,
    input  tnum_pkg::word_t          b_mask,
    output logic                     out_valid,
    input  logic                     out_ready,
    output tnum_pkg::word_t          product_value,
    output tnum_pkg::word_t          product_mask,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  tnum_pkg::variant_t       cfg_data
);

    tnum_pkg::state_t   state_reg, state_next;
    tnum_pkg::variant_t variant_reg;
    tnum_pkg::tri_t     a_reg, a_next;
    tnum_pkg::tri_t     b_reg, b_next;
    tnum_pkg::tri_t     acc_reg, acc_next;
    tnum_pkg::word_t    exact_reg, exact_next;
    logic               out_valid_reg, out_valid_next;
    tnum_pkg::tri_t     prod_reg, prod_next;

    tnum_pkg::add_req_t add_req;
    tnum_pkg::tri_t     add_x;
    tnum_pkg::tri_t     add_y;
    tnum_pkg::tri_t     add_res;

    logic               out_load;

    tnum_add_unit u_add (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (add_req),
        .x     (add_x),
        .y     (add_y),
        .res   (add_res)
    );

    assign in_ready      = (state_reg == tnum_pkg::ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign product_value = prod_reg.v;
    assign product_mask  = prod_reg.m;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tnum_pkg::ST_IDLE;
            variant_reg   <= tnum_pkg::VAR_UNION;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                variant_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        acc_reg   <= acc_next;
        exact_reg <= exact_next;
        prod_reg  <= prod_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        acc_next      = acc_reg;
        exact_next    = exact_reg;
        add_req.load  = 1'b0;
        add_req.merge = 1'b0;
        add_x         = acc_reg;
        add_y         = b_reg;
        out_load      = 1'b0;

        case (state_reg)
            tnum_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    a_next.v   = a_value;
                    a_next.m   = a_mask;
                    b_next.v   = b_value;
                    b_next.m   = b_mask;
                    acc_next   = '0;
                    exact_next = '0;
                    state_next = tnum_pkg::ST_STEP;
                end
            end
            tnum_pkg::ST_STEP:
            begin
                if ((a_reg.v | a_reg.m) == '0)
                begin
                    if (variant_reg == tnum_pkg::VAR_EXACT)
                    begin
                        add_req.load = 1'b1;
                        add_x.v      = exact_reg;
                        add_x.m      = '0;
                        add_y        = acc_reg;
                        state_next   = tnum_pkg::ST_FINAL;
                    end
                    else
                    begin
                        state_next = tnum_pkg::ST_DONE;
                    end
                end
                else
                begin
                    if (a_reg.v[0])
                    begin
                        exact_next = exact_reg + b_reg.v;
                    end
                    if (a_reg.v[0] || a_reg.m[0])
                    begin
                        add_req.load = 1'b1;
                        state_next   = tnum_pkg::ST_MERGE;
                        if (a_reg.v[0])
                        begin
                            if (variant_reg == tnum_pkg::VAR_EXACT)
                            begin
                                add_y.v = '0;
                                add_y.m = b_reg.m;
                            end
                        end
                        else if (variant_reg == tnum_pkg::VAR_UNION)
                        begin
                            add_req.merge = 1'b1;
                        end
                        else
                        begin
                            add_y.v = '0;
                            add_y.m = b_reg.v | b_reg.m;
                        end
                    end
                    else
                    begin
                        a_next.v = a_reg.v >> 1;
                        a_next.m = a_reg.m >> 1;
                        b_next.v = b_reg.v << 1;
                        b_next.m = b_reg.m << 1;
                    end
                end
            end
            tnum_pkg::ST_MERGE:
            begin
                acc_next   = add_res;
                a_next.v   = a_reg.v >> 1;
                a_next.m   = a_reg.m >> 1;
                b_next.v   = b_reg.v << 1;
                b_next.m   = b_reg.m << 1;
                state_next = tnum_pkg::ST_STEP;
            end
            tnum_pkg::ST_FINAL:
            begin
                acc_next   = add_res;
                state_next = tnum_pkg::ST_DONE;
            end
            tnum_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = tnum_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tnum_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        prod_next      = prod_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            prod_next      = acc_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == tnum_pkg::ST_STEP))
        else $error("Accepted transaction did not start the bit loop.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tnum_pkg::ST_MERGE) |-> ($past(state_reg) == tnum_pkg::ST_STEP))
        else $error("Adder result taken without a preceding load.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == tnum_pkg::ST_DONE))
        else $error("Result presented without completing the multiplication.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tnum_pkg::ST_FINAL) |-> (variant_reg == tnum_pkg::VAR_EXACT))
        else $error("Closing addition entered outside the exact-value rule.");

endmodule

### rtl/tnum_add_unit.sv
// ----------------------------------------------------------------------------
// Shared tristate adder
// Two-phase tristate addition: the load cycle registers the value and mask
// sums, the next cycle resolves carry uncertainty and optionally forms the
// union of the first operand with the sum.
// ----------------------------------------------------------------------------
module tnum_add_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  tnum_pkg::add_req_t req,
    input  tnum_pkg::tri_t     x,
    input  tnum_pkg::tri_t     y,
    output tnum_pkg::tri_t     res
);

    tnum_pkg::word_t sv_reg;
    tnum_pkg::word_t sm_reg;
    tnum_pkg::word_t orm_reg;
    tnum_pkg::tri_t  x_reg;
    logic            merge_reg;

    tnum_pkg::word_t chi;
    tnum_pkg::word_t mu;
    tnum_pkg::word_t add_v;
    tnum_pkg::word_t mu_u;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merge_reg <= 1'b0;
        end
        else if (req.load)
        begin
            merge_reg <= req.merge;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            sv_reg  <= x.v + y.v;
            sm_reg  <= x.m + y.m;
            orm_reg <= x.m | y.m;
            x_reg   <= x;
        end
    end

    always_comb
    begin
        chi   = (sv_reg + sm_reg) ^ sv_reg;
        mu    = chi | orm_reg;
        add_v = sv_reg & ~mu;
        mu_u  = (x_reg.v ^ add_v) | x_reg.m | mu;
        if (merge_reg)
        begin
            res.v = x_reg.v & add_v & ~mu_u;
            res.m = mu_u;
        end
        else
        begin
            res.v = add_v;
            res.m = mu;
        end
    end

endmodule
